@@ rtl/cmpt_pkg.sv @@
// ----------------------------------------------------------------------------
// cmpt_pkg
// shared types and constants of the carrier modulated pulse train
// ----------------------------------------------------------------------------
package cmpt_pkg;

    localparam int DURATION_BITS = 32;
    localparam int DUR_IN_W      = 32;
    localparam int HALF_W        = 23;
    localparam int CMP_W         = (DURATION_BITS > HALF_W) ? DURATION_BITS : HALF_W;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_STOP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_IDLE_LEVEL  = 2'd0,
        REG_CARRIER_EN  = 2'd1,
        REG_HALF_PERIOD = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]          command;
        logic [DUR_IN_W-1:0] duration;
    } t_in_word;

    typedef struct packed {
        logic pin_level;
        logic segment_ready;
        logic error_flag;
    } t_out_word;

    typedef struct packed {
        logic              idle_level;
        logic              carrier_enable;
        logic [HALF_W-1:0] carrier_half_period;
    } t_cfg;

endpackage

@@ rtl/cmpt_cfg.sv @@
// ----------------------------------------------------------------------------
// cmpt_cfg
// configuration registers written through the plain write port
// ----------------------------------------------------------------------------
module cmpt_cfg
    import cmpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [HALF_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_level          <= 1'b0;
            r_cfg.carrier_enable      <= 1'b0;
            r_cfg.carrier_half_period <= HALF_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IDLE_LEVEL:  r_cfg.idle_level          <= i_cfg_data[0];
                REG_CARRIER_EN:  r_cfg.carrier_enable      <= i_cfg_data[0];
                REG_HALF_PERIOD: r_cfg.carrier_half_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/cmpt_core.sv @@
// ----------------------------------------------------------------------------
// cmpt_core
// segment state and its combinational update for one command word
// ----------------------------------------------------------------------------
module cmpt_core
    import cmpt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_res
);

    logic                     r_pin, n_pin;
    logic                     r_phase, n_phase;
    logic [DURATION_BITS-1:0] r_rem, n_rem;
    logic [HALF_W-1:0]        r_hc, n_hc;
    logic                     r_high, n_high;
    logic                     r_busy, n_busy;
    logic                     r_err, n_err;
    logic                     r_segc, n_segc;

    logic [HALF_W-1:0]        half_len;
    logic [DURATION_BITS-1:0] dur;
    logic [DURATION_BITS-1:0] rem_dec;
    logic [HALF_W-1:0]        hc_dec;
    logic [CMP_W-1:0]         limit;

    // zero half period counts as one
    assign half_len = (i_cfg.carrier_half_period == '0) ? HALF_W'(1)
                                                        : i_cfg.carrier_half_period;
    assign dur      = DURATION_BITS'(i_word.duration);
    assign rem_dec  = (r_rem != '0) ? r_rem - DURATION_BITS'(1) : r_rem;
    assign hc_dec   = (r_hc != '0) ? r_hc - HALF_W'(1) : r_hc;
    assign limit    = i_cfg.carrier_enable ? CMP_W'(half_len) : '0;

    always_comb begin
        n_pin   = r_pin;
        n_phase = r_phase;
        n_rem   = r_rem;
        n_hc    = r_hc;
        n_high  = r_high;
        n_busy  = r_busy;
        n_err   = r_err;
        n_segc  = r_segc;
        case (t_cmd'(i_word.command))
            CMD_START, CMD_STOP: begin
                n_pin   = i_cfg.idle_level;
                n_phase = i_cfg.idle_level;
                n_rem   = '0;
                n_hc    = '0;
                n_high  = 1'b0;
                n_busy  = 1'b0;
                n_segc  = 1'b0;
                if (t_cmd'(i_word.command) == CMD_START) begin
                    n_err = 1'b0;
                end
            end
            CMD_LOAD: begin
                if (!r_busy && !r_err) begin
                    if (CMP_W'(dur) <= limit) begin
                        // too short: abort to idle
                        n_err   = 1'b1;
                        n_pin   = i_cfg.idle_level;
                        n_phase = i_cfg.idle_level;
                        n_rem   = '0;
                        n_hc    = '0;
                        n_high  = 1'b0;
                        n_segc  = 1'b0;
                    end else begin
                        n_rem  = dur;
                        n_busy = 1'b1;
                        if (i_cfg.carrier_enable && (r_phase == i_cfg.idle_level)) begin
                            n_segc = 1'b1;
                            n_high = 1'b1;
                            n_hc   = half_len;
                            n_pin  = 1'b1;
                        end else begin
                            n_segc = 1'b0;
                            n_pin  = r_phase;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (r_busy) begin
                    n_rem = rem_dec;
                    n_hc  = hc_dec;
                    if ((!r_segc && rem_dec == '0) ||
                        (r_segc && hc_dec == '0 && !r_high &&
                         CMP_W'(rem_dec) < CMP_W'(half_len))) begin
                        // end of segment: toggle phase
                        n_phase = ~r_phase;
                        n_pin   = ~r_phase;
                        n_busy  = 1'b0;
                        n_segc  = 1'b0;
                        n_high  = 1'b0;
                        n_hc    = '0;
                        n_rem   = '0;
                    end else if (r_segc && hc_dec == '0) begin
                        n_high = ~r_high;
                        n_pin  = ~r_high;
                        n_hc   = half_len;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin   <= 1'b0;
            r_phase <= 1'b0;
            r_rem   <= '0;
            r_hc    <= '0;
            r_high  <= 1'b0;
            r_busy  <= 1'b0;
            r_err   <= 1'b0;
            r_segc  <= 1'b0;
        end else if (i_en) begin
            r_pin   <= n_pin;
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_hc    <= n_hc;
            r_high  <= n_high;
            r_busy  <= n_busy;
            r_err   <= n_err;
            r_segc  <= n_segc;
        end
    end

    assign o_res.pin_level     = n_pin;
    assign o_res.segment_ready = ~n_busy;
    assign o_res.error_flag    = n_err;

`ifndef SYNTH
    a_busy_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_err))
        else $error("segment running with error set");
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_rem == '0 && !r_segc && !r_high))
        else $error("stale segment state while idle");
    a_hold_no_carrier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_segc && i_en && t_cmd'(i_word.command) == CMD_TICK
         && r_rem > DURATION_BITS'(1)) |=> (r_pin == $past(r_pin)))
        else $error("held segment pin moved mid segment");
`endif

endmodule

@@ rtl/carrier_modulated_pulse_train.sv @@
// ----------------------------------------------------------------------------
// carrier_modulated_pulse_train
// drives one pin through alternating mark/space segments with carrier bursts
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | word
//  in      | input     | i_in_valid / o_in_stall | t_in_word  (command, duration)
//  out     | output    | o_out_valid / i_out_stall | t_out_word (pin, ready, error)
//  cfg     | input     | i_cfg_we               | index + 23-bit data
//
//  one word per cycle unless out stalls; exactly one result word per command word
//  each word passes the input register, state update, result register
//  the state update is a single decrement/compare pass, so the words stream
//  synchronous active-low reset; config reg half period resets to 1
//  an out stall backs up into the input register, then raises o_in_stall
// ----------------------------------------------------------------------------
module carrier_modulated_pulse_train
    import cmpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command words
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in,
    // result words
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out,
    // configuration
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [HALF_W-1:0] i_cfg_data
);

    // input register
    logic      r_in_valid;
    t_in_word  r_in;
    // result register
    logic      r_out_valid;
    t_out_word r_out;

    t_cfg      cfg;
    t_out_word res;
    logic      adv;
    logic      in_acc;

    // a held word moves on when the result register is free or draining
    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    cmpt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cmpt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_word  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // input register: payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");
    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_out_valid)
        else $error("processed word lost its result");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> r_in_valid)
        else $error("held command word dropped");
`endif

endmodule

@@ tb/sv/carrier_modulated_pulse_train_test.sv @@
// ----------------------------------------------------------------------------
// carrier_modulated_pulse_train_test
// self-checking bench for the mark/space pulse train with carrier bursts:
// a queue-fed driver streams command words, a shadow of the pin logic turns
// each accepted word into the pin/ready/error word it must produce, and a
// monitor compares every result word in order; phases run under several
// register settings, with random gaps on both sides and one long out stall
// ----------------------------------------------------------------------------
module carrier_modulated_pulse_train_test;
    import cmpt_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = 8;     // result latency plus margin
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake
    localparam int unsigned HOLD_AT_RESULT = 300;   // where the long out stall starts
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned PHASE_WORDS    = 120;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_word          i_in        = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_word         o_out;
    logic              i_cfg_we    = 1'b0;
    logic [1:0]        i_cfg_index = REG_IDLE_LEVEL;
    logic [HALF_W-1:0] i_cfg_data  = '0;

    carrier_modulated_pulse_train u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_in_word    command_q[$];      // words waiting to be offered
    t_out_word   pin_state_q[$];    // pin/ready/error words still owed by the block
    int unsigned n_queued   = 0;
    int unsigned n_results  = 0;
    int unsigned n_bad      = 0;
    int unsigned idle_run   = 0;
    int unsigned hold_left  = 0;
    logic        no_gaps    = 1'b0; // one phase runs with both sides always ready

    // shadow of the programmed registers
    logic              cf_idle    = 1'b0;
    logic              cf_carrier = 1'b0;
    logic [HALF_W-1:0] cf_half    = HALF_W'(1);

    // shadow of the pin logic
    logic                     sh_pin      = 1'b0;
    logic                     sh_phase    = 1'b0;
    logic [DURATION_BITS-1:0] sh_left     = '0;
    logic [HALF_W-1:0]        sh_half_cnt = '0;
    logic                     sh_high     = 1'b0;
    logic                     sh_busy     = 1'b0;
    logic                     sh_err      = 1'b0;
    logic                     sh_burst    = 1'b0;  // segment runs with carrier

    // ------------------------------------------------------------------------
    // pin logic shadow
    // ------------------------------------------------------------------------

    // a zero half period counts as one tick
    function automatic logic [HALF_W-1:0] half_ticks();
        return (cf_half == '0) ? HALF_W'(1) : cf_half;
    endfunction

    task automatic return_to_idle();
        sh_pin      = cf_idle;
        sh_phase    = cf_idle;
        sh_left     = '0;
        sh_half_cnt = '0;
        sh_high     = 1'b0;
        sh_busy     = 1'b0;
        sh_burst    = 1'b0;
    endtask

    // segment over: flip the phase and park the pin on it
    task automatic close_segment();
        sh_phase    = ~sh_phase;
        sh_pin      = sh_phase;
        sh_busy     = 1'b0;
        sh_burst    = 1'b0;
        sh_high     = 1'b0;
        sh_half_cnt = '0;
        sh_left     = '0;
    endtask

    task automatic advance_pin(input t_in_word w, output t_out_word r);
        logic [DURATION_BITS-1:0] dur;
        logic [DURATION_BITS-1:0] too_short;
        dur       = w.duration[DURATION_BITS-1:0];
        too_short = cf_carrier ? DURATION_BITS'(half_ticks()) : '0;
        case (t_cmd'(w.command))
            CMD_START: begin
                return_to_idle();
                sh_err = 1'b0;
            end
            CMD_LOAD: begin
                // ignored while a segment runs or after an abort
                if (!sh_busy && !sh_err) begin
                    if (dur <= too_short) begin
                        sh_err = 1'b1;
                        return_to_idle();
                    end else begin
                        sh_left = dur;
                        sh_busy = 1'b1;
                        if (cf_carrier && sh_phase == cf_idle) begin
                            sh_burst    = 1'b1;
                            sh_high     = 1'b1;
                            sh_half_cnt = half_ticks();
                            sh_pin      = 1'b1;
                        end else begin
                            sh_burst = 1'b0;
                            sh_pin   = sh_phase;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (sh_busy) begin
                    // duration saturates, a started carrier period always completes
                    if (sh_left != '0) sh_left = sh_left - DURATION_BITS'(1);
                    if (!sh_burst) begin
                        if (sh_left == '0) close_segment();
                    end else begin
                        if (sh_half_cnt != '0) sh_half_cnt = sh_half_cnt - HALF_W'(1);
                        if (sh_half_cnt == '0) begin
                            if (sh_high) begin
                                sh_high     = 1'b0;
                                sh_pin      = 1'b0;
                                sh_half_cnt = half_ticks();
                            end else if (sh_left >= DURATION_BITS'(half_ticks())) begin
                                sh_high     = 1'b1;
                                sh_pin      = 1'b1;
                                sh_half_cnt = half_ticks();
                            end else begin
                                close_segment();
                            end
                        end
                    end
                end
            end
            CMD_STOP: begin
                // error flag survives a stop
                return_to_idle();
            end
            default: ;
        endcase
        r.pin_level     = sh_pin;
        r.segment_ready = ~sh_busy;
        r.error_flag    = sh_err;
    endtask

    // ------------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_bad(input string msg);
        n_bad++;
        $display("MISMATCH: %s", msg);
    endtask

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want)
            report_bad($sformatf("result %0d %s got %b want %b", n_results, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // driver: offers the head of command_q, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word owed;
        logic      offer;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                advance_pin(i_in, owed);
                pin_state_q.push_back(owed);
                void'(command_q.pop_front());
            end
            // a stalled word stays put
            if (!(i_in_valid && o_in_stall)) begin
                offer = (command_q.size() != 0)
                        && (no_gaps || $urandom_range(0, 99) >= 8);
                i_in_valid <= offer;
                if (offer) i_in <= command_q[0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compares every accepted result word, drives the out stall
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word owed;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (pin_state_q.size() == 0) begin
                    report_bad($sformatf("result %0d arrived with nothing owed", n_results));
                end else begin
                    owed = pin_state_q.pop_front();
                    check_field("pin_level", o_out.pin_level, owed.pin_level);
                    check_field("segment_ready", o_out.segment_ready, owed.segment_ready);
                    check_field("error_flag", o_out.error_flag, owed.error_flag);
                end
                // one long hold-off so the block backs up into its input
                if (n_results == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !no_gaps && ($urandom_range(0, 99) < 8);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run after too long without any handshake
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
            if (idle_run == WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic push_word(input t_cmd c, input logic [DUR_IN_W-1:0] d);
        t_in_word w;
        w.command  = c;
        w.duration = d;
        command_q.push_back(w);
        n_queued++;
    endtask

    // wait until every word is through, then let the pipeline settle
    task automatic drain();
        while (command_q.size() != 0 || pin_state_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // registers change only with the block empty
    task automatic write_reg(input t_reg_idx idx, input logic [HALF_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_IDLE_LEVEL:  cf_idle    = val[0];
            REG_CARRIER_EN:  cf_carrier = val[0];
            REG_HALF_PERIOD: cf_half    = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic idle, input logic carrier,
                            input logic [HALF_W-1:0] half);
        write_reg(REG_IDLE_LEVEL, HALF_W'(idle));
        write_reg(REG_CARRIER_EN, HALF_W'(carrier));
        write_reg(REG_HALF_PERIOD, half);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // usually a start, then one to six segments, mostly with ticks to finish each
    task automatic queue_burst();
        int unsigned       h;
        int unsigned       span;
        int unsigned       ticks;
        int unsigned       roll;
        logic [DUR_IN_W-1:0] dur;
        h    = 32'(half_ticks());
        span = (h > 12) ? 40 : 3 * h + 4;
        roll = $urandom_range(0, 99);
        if (roll < 85)      push_word(CMD_START, $urandom);
        else if (roll < 92) push_word(CMD_STOP, $urandom);
        repeat ($urandom_range(1, 6)) begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                dur = $urandom;
            else if (roll < 20)  // right at the too-short boundary
                dur = cf_carrier ? h + $urandom_range(0, 1) : $urandom_range(0, 1);
            else
                dur = $urandom_range(0, span);
            push_word(CMD_LOAD, dur);
            ticks = (dur > 80) ? 80 : dur + 2 * h + $urandom_range(0, 3);
            if (ticks > 80) ticks = 80;
            // sometimes cut short so the next load lands on a busy segment
            if ($urandom_range(0, 9) == 0) ticks = $urandom_range(0, ticks);
            repeat (ticks) push_word(CMD_TICK, $urandom);
            if ($urandom_range(0, 99) < 8)
                push_word(t_cmd'($urandom_range(0, 3)), $urandom);
        end
    endtask

    task automatic run_phase(input logic idle, input logic carrier,
                             input logic [HALF_W-1:0] half, input logic quiet);
        int unsigned stop_at;
        set_mode(idle, carrier, half);
        no_gaps = quiet;
        stop_at = n_queued + PHASE_WORDS;
        while (n_queued < stop_at) queue_burst();
        drain();
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: idle low, no carrier, half period one
        push_word(CMD_TICK, '0);           // tick with nothing running
        push_word(CMD_LOAD, '0);           // zero length aborts
        push_word(CMD_LOAD, 32'd5);        // ignored after abort
        push_word(CMD_STOP, '0);           // stop keeps the error
        push_word(CMD_START, '1);          // start clears it
        push_word(CMD_LOAD, 32'd3);
        push_word(CMD_LOAD, 32'd2);        // busy, ignored
        repeat (3) push_word(CMD_TICK, '1);
        push_word(CMD_LOAD, '1);           // widest duration
        push_word(CMD_TICK, '0);
        push_word(CMD_START, '0);
        drain();

        // carrier on, idle high, half period two
        set_mode(1'b1, 1'b1, HALF_W'(2));
        push_word(CMD_START, '0);
        push_word(CMD_LOAD, 32'd2);        // equal to the half period aborts
        push_word(CMD_START, '0);
        push_word(CMD_LOAD, 32'd3);        // one burst period plus overshoot
        repeat (5) push_word(CMD_TICK, '0);
        push_word(CMD_LOAD, 32'd4);        // opposite phase holds the level
        push_word(CMD_STOP, '0);
        drain();

        // random phases across the settings, extremes included
        run_phase(1'b0, 1'b1, HALF_W'(1), 1'b0);
        run_phase(1'b1, 1'b1, HALF_W'(3), 1'b0);
        run_phase(1'b0, 1'b0, HALF_W'(7), 1'b0);
        run_phase(1'b1, 1'b0, HALF_W'(0), 1'b0);
        run_phase(1'b0, 1'b1, HALF_W'(0), 1'b0);
        run_phase(1'b1, 1'b1, '1, 1'b0);
        run_phase(1'b0, 1'b1, HALF_W'(2), 1'b0);
        run_phase(1'b1, 1'b1, HALF_W'(5), 1'b1);
        run_phase(1'b0, 1'b0, HALF_W'(5000000), 1'b0);
        run_phase(1'b1, 1'b1, HALF_W'(4), 1'b0);

        if (n_bad == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
rtl/cmpt_pkg.sv
rtl/cmpt_cfg.sv
rtl/cmpt_core.sv
rtl/carrier_modulated_pulse_train.sv
tb/sv/carrier_modulated_pulse_train_test.sv
